### rtl/aplm_pkg.sv
// shared types, codes and constants of the peak level meter
package aplm_pkg;

    localparam int LEVEL_FRACTION_BITS_DEF = 16;
    localparam int SAMPLE_W = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 32;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_CODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KIND       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BIG_ENDIAN = 2'd2;

    // container width codes
    localparam logic [1:0] WIDTH_8  = 2'd0;
    localparam logic [1:0] WIDTH_16 = 2'd1;
    localparam logic [1:0] WIDTH_32 = 2'd2;

    // sample kind codes
    localparam logic [1:0] KIND_SIGNED   = 2'd0;
    localparam logic [1:0] KIND_UNSIGNED = 2'd1;
    localparam logic [1:0] KIND_FLOAT    = 2'd2;

    localparam logic [31:0] FS_S8  = 32'd127;
    localparam logic [31:0] FS_U8  = 32'd255;
    localparam logic [31:0] FS_S16 = 32'd32767;
    localparam logic [31:0] FS_U16 = 32'd65535;
    localparam logic [31:0] FS_S32 = 32'h7fff_ffff;
    localparam logic [31:0] FS_U32 = 32'hffff_ffff;

    typedef struct packed {
        logic [1:0] width_code;
        logic [1:0] kind;
        logic       big_endian;
    } cfg_t;

    typedef struct packed {
        logic        start;
        logic [31:0] peak;
        logic [31:0] full_scale;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

### rtl/aplm_if.sv
// channel interfaces: sample input, result output and configuration writes
interface aplm_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] sample_bits;
    logic        last_in_buffer;

    modport source (output valid, output sample_bits, output last_in_buffer, input ready);
    modport sink (input valid, input sample_bits, input last_in_buffer, output ready);
endinterface

interface aplm_out_if #(
    parameter int LEVEL_FRACTION_BITS = aplm_pkg::LEVEL_FRACTION_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic [31:0]                  peak_value;
    logic [LEVEL_FRACTION_BITS:0] level;

    modport source (output valid, output peak_value, output level, input ready);
    modport sink (input valid, input peak_value, input level, output ready);
endinterface

interface aplm_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [aplm_pkg::CFG_INDEX_W-1:0]    index;
    logic [aplm_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/aplm_decode.sv
// sample decoder: byte order, sign and float handling down to a magnitude
module aplm_decode (
    input  logic [31:0]    raw,
    input  aplm_pkg::cfg_t cfg,
    output logic [31:0]    magnitude,
    output logic [31:0]    full_scale
);
    logic [31:0] v;
    logic [31:0] float_mag;
    logic [7:0]  ex;
    logic [23:0] mant;

    always_comb
    begin
        unique case (cfg.width_code)
            aplm_pkg::WIDTH_8:  v = {24'd0, raw[7:0]};
            aplm_pkg::WIDTH_16: v = cfg.big_endian ? {16'd0, raw[7:0], raw[15:8]}
                                                   : {16'd0, raw[15:0]};
            default:            v = cfg.big_endian ? {raw[7:0], raw[15:8], raw[23:16], raw[31:24]}
                                                   : raw;
        endcase
    end

    // value times 2^31 is the mantissa shifted by exponent minus 119
    assign ex   = v[30:23];
    assign mant = {1'b1, v[22:0]};

    always_comb
    begin
        if (ex == 8'hff || ex >= 8'd128)
            float_mag = 32'hffff_ffff;
        else if (ex == 8'd0)
            float_mag = 32'd0;
        else if (ex >= 8'd119)
            float_mag = {8'd0, mant} << 4'(ex - 8'd119);
        else if (ex >= 8'd96)
            float_mag = {8'd0, mant >> 5'(8'd119 - ex)};
        else
            float_mag = 32'd0;
    end

    always_comb
    begin
        unique case (cfg.kind)
            aplm_pkg::KIND_UNSIGNED: magnitude = v;
            aplm_pkg::KIND_FLOAT:    magnitude = float_mag;
            default:
            begin
                unique case (cfg.width_code)
                    aplm_pkg::WIDTH_8:  magnitude = v[7]  ? {24'd0, 8'(~v[7:0] + 8'd1)} : v;
                    aplm_pkg::WIDTH_16: magnitude = v[15] ? {16'd0, 16'(~v[15:0] + 16'd1)} : v;
                    default:            magnitude = v[31] ? 32'(~v + 32'd1) : v;
                endcase
            end
        endcase
    end

    // zero marks a combination with no defined full scale
    always_comb
    begin
        full_scale = 32'd0;
        unique case (cfg.width_code)
            aplm_pkg::WIDTH_8:
            begin
                if (cfg.kind == aplm_pkg::KIND_SIGNED)        full_scale = aplm_pkg::FS_S8;
                else if (cfg.kind == aplm_pkg::KIND_UNSIGNED) full_scale = aplm_pkg::FS_U8;
            end
            aplm_pkg::WIDTH_16:
            begin
                if (cfg.kind == aplm_pkg::KIND_SIGNED)        full_scale = aplm_pkg::FS_S16;
                else if (cfg.kind == aplm_pkg::KIND_UNSIGNED) full_scale = aplm_pkg::FS_U16;
            end
            aplm_pkg::WIDTH_32:
            begin
                if (cfg.kind == aplm_pkg::KIND_SIGNED || cfg.kind == aplm_pkg::KIND_FLOAT)
                    full_scale = aplm_pkg::FS_S32;
                else if (cfg.kind == aplm_pkg::KIND_UNSIGNED)
                    full_scale = aplm_pkg::FS_U32;
            end
            default: full_scale = 32'd0;
        endcase
    end
endmodule

### rtl/aplm_div.sv
// level divider: folds the dividend onto a 2^n - 1 full scale, one fold per cycle
module aplm_div #(
    parameter int LEVEL_FRACTION_BITS = aplm_pkg::LEVEL_FRACTION_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  aplm_pkg::div_ctrl_t          ctrl,
    output aplm_pkg::div_stat_t          stat,
    output logic [LEVEL_FRACTION_BITS:0] quotient
);
    localparam int DVD_W = 32 + LEVEL_FRACTION_BITS;
    localparam int QUO_W = LEVEL_FRACTION_BITS + 1;

    logic [DVD_W-1:0]   rem_reg, rem_next;
    logic [31:0]        mask_reg, mask_next;
    logic [5:0]         shift_reg, shift_next;
    logic [QUO_W-1:0]   quo_reg, quo_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [5:0]         start_shift;
    logic [DVD_W-1:0]   high_part;
    logic [DVD_W-1:0]   low_part;
    logic               above_mask;

    // every full scale is 2^n - 1, n picked from the format
    always_comb
    begin
        unique case (ctrl.full_scale)
            aplm_pkg::FS_S8:  start_shift = 6'd7;
            aplm_pkg::FS_U8:  start_shift = 6'd8;
            aplm_pkg::FS_S16: start_shift = 6'd15;
            aplm_pkg::FS_U16: start_shift = 6'd16;
            aplm_pkg::FS_S32: start_shift = 6'd31;
            default:          start_shift = 6'd32;
        endcase
    end

    assign high_part  = rem_reg >> shift_reg;
    assign low_part   = rem_reg & {{(DVD_W-32){1'b0}}, mask_reg};
    assign above_mask = (high_part != '0);

    always_comb
    begin
        rem_next   = rem_reg;
        mask_next  = mask_reg;
        shift_next = shift_reg;
        quo_next   = quo_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (ctrl.start)
        begin
            rem_next   = {ctrl.peak, LEVEL_FRACTION_BITS'(0)};
            mask_next  = ctrl.full_scale;
            shift_next = start_shift;
            quo_next   = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            if (above_mask)
            begin
                // a*2^n + b equals a*(2^n - 1) + (a + b)
                rem_next = high_part + low_part;
                quo_next = quo_reg + QUO_W'(high_part);
            end
            else
            begin
                // remainder is at most the divisor here
                if (low_part[31:0] == mask_reg)
                    quo_next = quo_reg + QUO_W'(1);
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        mask_reg  <= mask_next;
        shift_reg <= shift_next;
        quo_reg   <= quo_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
endmodule

### rtl/audio_peak_level_meter_core.sv
// top level: configuration registers, peak tracking sequencer and output register
//
//  channel   role    payload                          transfer when
//  cfg       sink    index, data                      valid && ready (ready always high)
//  sample    sink    sample_bits, last_in_buffer      valid && ready
//  result    source  peak_value, level                valid && ready
//
//  an ordinary sample is captured, then decoded and compared with the running peak
//  a last sample of a supported format then runs the divider, which folds the clamped peak
//  down (8-bit formats the slowest), and the result is loaded once the result register is free
//  reset clears the registers to 16-bit signed little endian and the peak to zero
//  the result register holds while result.ready is low; the next sample is
//  still taken, and a later result waits for the register to empty
module audio_peak_level_meter_core #(
    parameter int LEVEL_FRACTION_BITS = aplm_pkg::LEVEL_FRACTION_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    aplm_cfg_if.sink     cfg,
    aplm_in_if.sink      sample,
    aplm_out_if.source   result
);
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_PEAK = 3'b010,
        ST_DIV  = 3'b100
    } state_t;

    state_t                         state_reg, state_next;
    aplm_pkg::cfg_t                 cfg_reg, cfg_next;
    logic [31:0]                    raw_reg, raw_next;
    logic                           last_reg, last_next;
    logic [31:0]                    peak_reg, peak_next;
    logic [31:0]                    clamp_reg, clamp_next;
    logic                           out_valid_reg, out_valid_next;
    logic [31:0]                    out_peak_reg, out_peak_next;
    logic [LEVEL_FRACTION_BITS:0]   out_level_reg, out_level_next;

    logic [31:0]                    magnitude;
    logic [31:0]                    full_scale;
    logic [31:0]                    new_peak;
    logic [31:0]                    clamped;
    logic                           out_free;
    aplm_pkg::div_ctrl_t            div_ctrl;
    aplm_pkg::div_stat_t            div_stat;
    logic [LEVEL_FRACTION_BITS:0]   quotient;

    aplm_decode u_decode (
        .raw        (raw_reg),
        .cfg        (cfg_reg),
        .magnitude  (magnitude),
        .full_scale (full_scale)
    );

    aplm_div #(
        .LEVEL_FRACTION_BITS (LEVEL_FRACTION_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .stat     (div_stat),
        .quotient (quotient)
    );

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                aplm_pkg::REG_WIDTH_CODE: cfg_next.width_code = cfg.data[1:0];
                aplm_pkg::REG_KIND:       cfg_next.kind       = cfg.data[1:0];
                aplm_pkg::REG_BIG_ENDIAN: cfg_next.big_endian = cfg.data[0];
                default: ;
            endcase
        end
    end

    assign sample.ready = (state_reg == ST_IDLE);
    assign out_free     = !out_valid_reg || result.ready;

    // unsupported formats leave the peak alone
    assign new_peak = (full_scale != 32'd0 && magnitude > peak_reg) ? magnitude : peak_reg;
    assign clamped  = (new_peak > full_scale) ? full_scale : new_peak;

    assign div_ctrl.start      = (state_reg == ST_PEAK) && last_reg && (full_scale != 32'd0);
    assign div_ctrl.peak       = clamped;
    assign div_ctrl.full_scale = full_scale;

    always_comb
    begin
        state_next     = state_reg;
        raw_next       = raw_reg;
        last_next      = last_reg;
        peak_next      = peak_reg;
        clamp_next     = clamp_reg;
        out_valid_next = out_valid_reg;
        out_peak_next  = out_peak_reg;
        out_level_next = out_level_reg;

        if (out_valid_reg && result.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample.valid)
                begin
                    raw_next   = sample.sample_bits;
                    last_next  = sample.last_in_buffer;
                    state_next = ST_PEAK;
                end
            end
            ST_PEAK:
            begin
                if (last_reg)
                begin
                    peak_next  = 32'd0;
                    clamp_next = clamped;
                    state_next = (full_scale != 32'd0) ? ST_DIV : ST_IDLE;
                end
                else
                begin
                    peak_next  = new_peak;
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (!div_stat.busy && out_free)
                begin
                    out_valid_next = 1'b1;
                    out_peak_next  = clamp_reg;
                    out_level_next = quotient;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            cfg_reg.width_code <= aplm_pkg::WIDTH_16;
            cfg_reg.kind       <= aplm_pkg::KIND_SIGNED;
            cfg_reg.big_endian <= 1'b0;
            peak_reg           <= 32'd0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cfg_reg       <= cfg_next;
            peak_reg      <= peak_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        raw_reg       <= raw_next;
        last_reg      <= last_next;
        clamp_reg     <= clamp_next;
        out_peak_reg  <= out_peak_next;
        out_level_reg <= out_level_next;
    end

    assign result.valid      = out_valid_reg;
    assign result.peak_value = out_peak_reg;
    assign result.level      = out_level_reg;

    // divider never runs while a new sample can be taken
    assert property (@(posedge clk) disable iff (!rst_n)
        sample.ready |-> !div_stat.busy)
        else $error("divider busy while sample channel is ready");

    // division finishes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == ST_DIV)
        else $error("division finished outside the divide state");

    // a clamped peak never gives a level above one
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.level <= {1'b1, LEVEL_FRACTION_BITS'(0)})
        else $error("level above full scale");

    // the last sample of a buffer clears the running peak
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PEAK && last_reg) |=> peak_reg == 32'd0)
        else $error("running peak not cleared at end of buffer");

    // a pending result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |=> $stable(result.peak_value) && result.valid)
        else $error("pending result changed");
endmodule
